@@ hdl/rgb_led_matrix_bitplane_scanner_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the bit-plane scanner
// Clocked, reset-gated assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef RGB_LED_MATRIX_BITPLANE_SCANNER_TOP_ASSERT_SVH
`define RGB_LED_MATRIX_BITPLANE_SCANNER_TOP_ASSERT_SVH

// plain property, sampled on the rising edge, off during reset
`define RLBS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// implication in the same cycle
`define RLBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

`endif

@@ hdl/rlbs_pkg.sv @@
// ----------------------------------------------------------------------------
// Bit-plane scanner package
// Sizes, request types, byte decode masks and the channel level table.
// ----------------------------------------------------------------------------
package rlbs_pkg;

  localparam int ROW_COUNT    = 8;
  localparam int COLUMN_COUNT = 8;
  localparam int PLANE_COUNT  = 16;

  localparam int PIXEL_W      = 6;
  localparam int CHAN_W       = 2;
  localparam int LEVEL_W      = 4;
  localparam int PIXEL_ROWS   = 8;
  localparam int PIX_ROW_W    = $clog2(PIXEL_ROWS);
  localparam int PIX_COL_W    = $clog2(COLUMN_COUNT);
  localparam int POS_W        = PIX_ROW_W + PIX_COL_W;
  localparam int ROW_W        = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int PLANE_W      = $clog2(PLANE_COUNT);
  localparam int ROW_DATA_W   = PIXEL_W * COLUMN_COUNT;

  localparam logic [7:0] RESTART_MASK = 8'b1000_0000;
  localparam logic [7:0] SHOW_MASK    = 8'b0100_0000;
  localparam logic [7:0] ALL_OFF      = 8'b1111_1111;

  localparam logic [LEVEL_W-1:0] LEVEL_MID  = 4'b0100;
  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 4'b1111;

  typedef enum logic {
    OP_RX_BYTE   = 1'b0,
    OP_SCAN_TICK = 1'b1
  } op_e;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } in_req_t;

  typedef struct packed {
    logic [7:0] red_columns;
    logic [7:0] green_columns;
    logic [7:0] blue_columns;
    logic [7:0] row_select;
  } out_req_t;

  typedef struct packed {
    logic               restart;
    logic               show;
    logic               write;
    logic [PIXEL_W-1:0] pixel;
  } store_cmd_t;

  function automatic logic [LEVEL_W-1:0] level_of(input logic [CHAN_W-1:0] code);
    logic [LEVEL_W-1:0] lvl;
    case (code)
      2'd0:    lvl = '0;
      2'd1:    lvl = LEVEL_W'(1);
      2'd2:    lvl = LEVEL_MID;
      default: lvl = LEVEL_FULL;
    endcase
    return lvl;
  endfunction

endpackage

@@ hdl/rlbs_store.sv @@
// ----------------------------------------------------------------------------
// Pixel stores
// Written and shown frames held as rows of packed pixels, with write position.
// ----------------------------------------------------------------------------
module rlbs_store (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cmd_valid_i,
  input  rlbs_pkg::store_cmd_t              cmd_i,
  input  logic [rlbs_pkg::PIX_ROW_W-1:0]    rd_row_i,
  output logic [rlbs_pkg::ROW_DATA_W-1:0]   rd_data_o
);
  import rlbs_pkg::*;

  logic [ROW_DATA_W-1:0] written_q [PIXEL_ROWS];
  logic [ROW_DATA_W-1:0] written_d [PIXEL_ROWS];
  logic [ROW_DATA_W-1:0] shown_q   [PIXEL_ROWS];
  logic [ROW_DATA_W-1:0] shown_d   [PIXEL_ROWS];
  logic [POS_W-1:0]      pos_q, pos_d;
  logic [PIX_ROW_W-1:0]  wr_row;
  logic [PIX_COL_W-1:0]  wr_col;

  assign wr_row = pos_q[POS_W-1:PIX_COL_W];
  assign wr_col = pos_q[PIX_COL_W-1:0];

  always_comb begin
    written_d = written_q;
    shown_d   = shown_q;
    pos_d     = pos_q;
    if (cmd_valid_i) begin
      if (cmd_i.restart) begin
        pos_d = '0;
      end else if (cmd_i.show) begin
        shown_d = written_q;
      end else if (cmd_i.write) begin
        written_d[wr_row][wr_col*PIXEL_W +: PIXEL_W] = cmd_i.pixel;
        pos_d = pos_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < PIXEL_ROWS; r++) begin
        written_q[r] <= '0;
        shown_q[r]   <= '0;
      end
      pos_q <= '0;
    end else begin
      written_q <= written_d;
      shown_q   <= shown_d;
      pos_q     <= pos_d;
    end
  end

  assign rd_data_o = shown_q[rd_row_i];

endmodule

@@ hdl/rlbs_scan.sv @@
// ----------------------------------------------------------------------------
// Scan sequencer
// Row and plane counters and the column compare for one scan tick.
// ----------------------------------------------------------------------------
module rlbs_scan (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             advance_i,
  input  logic [rlbs_pkg::ROW_DATA_W-1:0]  row_data_i,
  output logic [rlbs_pkg::PIX_ROW_W-1:0]   rd_row_o,
  output rlbs_pkg::out_req_t               result_o
);
  import rlbs_pkg::*;

  logic [ROW_W-1:0]   row_q, row_d;
  logic [PLANE_W-1:0] plane_q, plane_d;
  logic               in_grid;
  logic [PIXEL_W-1:0] px;

  assign rd_row_o = PIX_ROW_W'(row_q);
  assign in_grid  = (ROW_COUNT <= PIXEL_ROWS) || (32'(row_q) < PIXEL_ROWS);

  always_comb begin
    row_d   = row_q;
    plane_d = plane_q;
    if (advance_i) begin
      if (32'(row_q) == ROW_COUNT - 1) begin
        row_d   = '0;
        plane_d = plane_q + PLANE_W'(1);
      end else begin
        row_d = row_q + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      plane_q <= '0;
    end else begin
      row_q   <= row_d;
      plane_q <= plane_d;
    end
  end

  always_comb begin
    result_o.red_columns   = ALL_OFF;
    result_o.green_columns = ALL_OFF;
    result_o.blue_columns  = ALL_OFF;
    result_o.row_select    = '0;
    px                     = '0;
    if (in_grid) begin
      result_o.row_select = 8'(1) << PIX_ROW_W'(row_q);
      for (int c = 0; c < COLUMN_COUNT; c++) begin
        px = row_data_i[c*PIXEL_W +: PIXEL_W];
        if (level_of(px[5:4]) > plane_q) result_o.red_columns[COLUMN_COUNT-1-c] = 1'b0;
        if (level_of(px[3:2]) > plane_q) result_o.green_columns[c] = 1'b0;
        if (level_of(px[1:0]) > plane_q) result_o.blue_columns[c] = 1'b0;
      end
    end
  end

endmodule

@@ hdl/rgb_led_matrix_bitplane_scanner_top.sv @@
// A scan tick waits in the input register until the output slot is free; then its
// result is caught in the output register. Received bytes take no output slot.
// Throughput: one request per cycle while the output is not stalled.
// Reset clears both pixel stores, the write position and the scan counters at once.
// ----------------------------------------------------------------------------
// RGB LED matrix bit-plane scanner
// Input register, store update or column compute, then the result register.
// ----------------------------------------------------------------------------
module rgb_led_matrix_bitplane_scanner_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rlbs_pkg::in_req_t   in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rlbs_pkg::out_req_t  out_req_o
);
  import rlbs_pkg::*;

  logic                  s1_valid_q, s1_valid_d;
  in_req_t               s1_req_q;
  logic                  out_valid_q, out_valid_d;
  out_req_t              out_req_q;
  logic                  slot_free;
  logic                  s1_is_tick;
  logic                  s1_fire;
  logic                  in_fire;
  store_cmd_t            cmd;
  logic [PIX_ROW_W-1:0]  rd_row;
  logic [ROW_DATA_W-1:0] row_data;
  out_req_t              result;

  assign s1_is_tick = (s1_req_q.operation == OP_SCAN_TICK);
  assign slot_free  = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && (!s1_is_tick || slot_free);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  assign cmd.restart = (s1_req_q.rx_byte & RESTART_MASK) != '0;
  assign cmd.show    = !cmd.restart && ((s1_req_q.rx_byte & SHOW_MASK) != '0);
  assign cmd.write   = !cmd.restart && !cmd.show;
  assign cmd.pixel   = s1_req_q.rx_byte[PIXEL_W-1:0];

  rlbs_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s1_fire && !s1_is_tick),
    .cmd_i       (cmd),
    .rd_row_i    (rd_row),
    .rd_data_o   (row_data)
  );

  rlbs_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (s1_fire && s1_is_tick),
    .row_data_i (row_data),
    .rd_row_o   (rd_row),
    .result_o   (result)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_fire) s1_valid_d = 1'b0;
    if (in_fire) s1_valid_d = 1'b1;
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (s1_fire && s1_is_tick) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) s1_req_q <= in_req_i;
    if (s1_fire && s1_is_tick) out_req_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

endmodule

@@ hdl/rlbs_checker.sv @@
// ----------------------------------------------------------------------------
// Bit-plane scanner port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`include "rgb_led_matrix_bitplane_scanner_top_assert.svh"

module rlbs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input rlbs_pkg::in_req_t   in_req_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input rlbs_pkg::out_req_t  out_req_o
);
  import rlbs_pkg::*;

  logic stalled;
  logic blank_row;
  logic all_off;

  assign stalled   = out_valid_o && !out_ready_i;
  assign blank_row = out_valid_o && (out_req_o.row_select == '0);
  assign all_off   = (out_req_o.red_columns == ALL_OFF) && (out_req_o.green_columns == ALL_OFF)
                     && (out_req_o.blue_columns == ALL_OFF);

  `RLBS_ASSERT(a_out_hold, clk_i, rst_ni, stalled |=> out_valid_o && $stable(out_req_o))
  `RLBS_ASSERT_IMP(a_row_onehot, clk_i, rst_ni, out_valid_o, $onehot0(out_req_o.row_select))
  `RLBS_ASSERT_IMP(a_blank_off, clk_i, rst_ni, blank_row, all_off)
  `RLBS_ASSERT_IMP(a_ready_empty, clk_i, rst_ni, !out_valid_o, in_ready_o)

endmodule

bind rgb_led_matrix_bitplane_scanner_top rlbs_checker u_rlbs_checker (.*);
